### sv/sact_pkg.sv
// Package for the set-associative cache tag controller.
// Geometry constants, payload structs, state enum and the LFSR step function.
// No dependencies.
package sact_pkg;

    localparam int SETS     = 64;
    localparam int WAYS     = 8;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W   = 48;
    localparam int CORE_W   = 3;
    localparam int CNT_W    = 32;
    localparam int QDEPTH   = 2;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic [0:0] MODE_LRU  = 1'b0;
    localparam logic [0:0] MODE_RAND = 1'b1;
    localparam logic [0:0] REG_MODE  = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] line_addr;
        logic              write_op;
        logic [CORE_W-1:0] requester_core;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [2:0]        way_used;
        logic              evicted_valid;
        logic              evicted_dirty;
        logic [ADDR_W-1:0] evicted_addr;
        logic [CORE_W-1:0] evicted_core;
        logic [CNT_W-1:0]  read_total;
        logic [CNT_W-1:0]  write_total;
        logic [CNT_W-1:0]  read_miss_total;
        logic [CNT_W-1:0]  write_miss_total;
        logic [CNT_W-1:0]  dirty_evict_total;
    } t_rsp;

    // Queued request with its access stamp
    typedef struct packed {
        t_req              req;
        logic [ADDR_W-1:0] stamp;
    } t_job;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_OUT
    } t_state;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage

### sv/sact_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sact_pkg.
interface sact_req_if (input logic i_clk);
    logic            valid;
    logic            ready;
    sact_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sact_rsp_if (input logic i_clk);
    logic            valid;
    logic            ready;
    sact_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/set_assoc_cache_tag_controller_core.sv
// Set-associative cache tag controller, top level.
// A request passes the queue, the set read and the evaluate step before its result is valid.
// One access at a time: set read, evaluate with write-back, then the result is held until accepted.
// Reset: synchronous active low; a sweep over all SETS (64) sets clears the valid bits,
// during which requests queue but are not processed. Configuration writes taken always.
module set_assoc_cache_tag_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sact_req_if.sink    i_req,
    sact_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sact_pkg::*;

    logic  r_mode;
    logic  w_job_valid, w_job_pop;
    t_job  w_job;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MODE) ? {31'd0, r_mode} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LRU;
        end else if (psel && penable && pwrite && paddr == REG_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    sact_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_req       (i_req.data),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop),
        .o_job       (w_job)
    );

    sact_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job       (w_job),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_rsp       (o_rsp.data)
    );
endmodule

### sv/sact_front.sv
// Front end: accepts requests, stamps them with the access clock, queues them.
// Depends on sact_pkg.
module sact_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sact_pkg::t_req        i_req,
    output logic                  o_job_valid,
    input  logic                  i_job_pop,
    output sact_pkg::t_job        o_job
);
    import sact_pkg::*;

    t_job              r_q [QDEPTH];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic [ADDR_W-1:0] r_clock;
    logic              w_push;

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{req: i_req, stamp: r_clock};
        end
    end

    // Pointers, count and access clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
            r_clock <= '0;
        end else begin
            if (w_push) begin
                r_wp    <= ~r_wp;
                r_clock <= r_clock + 1'b1;
            end
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end
endmodule

### sv/sact_back.sv
// Back end: set read, hit/victim selection, set write-back, statistics.
// Depends on sact_pkg.
module sact_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mode,
    input  logic                  i_job_valid,
    output logic                  o_job_pop,
    input  sact_pkg::t_job        i_job,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sact_pkg::t_rsp        o_rsp
);
    import sact_pkg::*;

    localparam int WORD_W = 1 + ADDR_W + CORE_W + ADDR_W;

    // Per-set row of all ways: dirty, tag, owner, stamp
    logic [WAYS*WORD_W-1:0] r_mem [SETS];
    logic [WAYS*WORD_W-1:0] r_row;
    logic [WAYS-1:0]        r_vbits [SETS];
    logic [WAYS-1:0]        r_vrow;

    t_state            r_state, n_state;
    logic [SET_W-1:0]  r_clr;
    t_job              r_job;
    logic [15:0]       r_lfsr;
    t_rsp              r_rsp;
    logic [CNT_W-1:0]  r_rd, r_wr, r_rdm, r_wrm, r_dev;

    logic [SET_W-1:0]  w_set;
    logic              w_hit, w_full, w_wen, w_pop;
    logic [WAY_W-1:0]  w_way, w_hway, w_iway, w_lway, w_vway;
    logic [15:0]       w_lfsr_n;
    logic [WORD_W-1:0] w_word [WAYS];
    logic [WORD_W-1:0] w_vic;
    logic [WAYS*WORD_W-1:0] w_nrow;
    logic [WAYS-1:0]   w_nvrow;
    logic              w_ev_d;

    assign w_set = (SETS > 1) ? r_job.req.line_addr[SET_W-1:0] : '0;

    always_comb begin
        for (int w = 0; w < WAYS; w++) w_word[w] = r_row[w*WORD_W +: WORD_W];
    end

    // Hit, first free way and LRU search
    always_comb begin
        logic [ADDR_W-1:0] best;
        w_hit  = 1'b0;
        w_hway = '0;
        w_full = 1'b1;
        w_iway = '0;
        w_lway = '0;
        best   = w_word[0][ADDR_W-1:0];
        for (int w = WAYS-1; w >= 0; w--) begin
            if (r_vrow[w] && w_word[w][WORD_W-2 -: ADDR_W] == r_job.req.line_addr) begin
                w_hit  = 1'b1;
                w_hway = WAY_W'(w);
            end
            if (!r_vrow[w]) begin
                w_full = 1'b0;
                w_iway = WAY_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (w_word[w][ADDR_W-1:0] < best) begin
                best   = w_word[w][ADDR_W-1:0];
                w_lway = WAY_W'(w);
            end
        end
    end

    assign w_lfsr_n = lfsr_next(r_lfsr);
    assign w_vway   = (i_mode == MODE_RAND) ? w_lfsr_n[WAY_W-1:0] : w_lway;
    assign w_way    = w_hit ? w_hway : (w_full ? w_vway : w_iway);
    assign w_vic    = w_word[w_way];
    assign w_ev_d   = !w_hit && w_full && w_vic[WORD_W-1];

    // Updated row
    always_comb begin
        w_nrow  = r_row;
        w_nvrow = r_vrow;
        if (w_hit) begin
            w_nrow[w_way*WORD_W +: ADDR_W] = r_job.stamp;
            if (r_job.req.write_op) w_nrow[w_way*WORD_W + WORD_W-1] = 1'b1;
        end else begin
            w_nrow[w_way*WORD_W +: WORD_W] = {r_job.req.write_op, r_job.req.line_addr,
                                              r_job.req.requester_core, r_job.stamp};
            w_nvrow[w_way] = 1'b1;
        end
    end

    // Control
    always_comb begin
        n_state = r_state;
        w_pop   = 1'b0;
        w_wen   = 1'b0;
        case (r_state)
            ST_CLEAR: if (r_clr == SET_W'(SETS-1)) n_state = ST_READ;
            ST_READ: begin
                if (i_job_valid) begin
                    w_pop   = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                w_wen   = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT:  if (i_ready) n_state = ST_READ;
            default: n_state = ST_READ;
        endcase
    end

    assign o_job_pop = w_pop;
    assign o_valid   = (r_state == ST_OUT);
    assign o_rsp     = r_rsp;

    // Set memory: registered read, one write per access
    always_ff @(posedge i_clk) begin
        if (w_wen) r_mem[w_set] <= w_nrow;
        if (w_pop) r_row <= r_mem[(SETS > 1) ? i_job.req.line_addr[SET_W-1:0] : '0];
    end

    // Valid bits: cleared by sweep after reset
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) r_vbits[r_clr] <= '0;
        else if (w_wen) r_vbits[w_set] <= w_nvrow;
        if (w_pop) r_vrow <= r_vbits[(SETS > 1) ? i_job.req.line_addr[SET_W-1:0] : '0];
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) r_job <= i_job;
        if (w_wen) begin
            r_rsp.hit               <= w_hit;
            r_rsp.way_used          <= 3'(w_way);
            r_rsp.evicted_valid     <= !w_hit && w_full;
            r_rsp.evicted_dirty     <= w_ev_d;
            r_rsp.evicted_addr      <= (!w_hit && w_full) ? w_vic[WORD_W-2 -: ADDR_W] : '0;
            r_rsp.evicted_core      <= (!w_hit && w_full) ? w_vic[ADDR_W +: CORE_W] : '0;
            r_rsp.read_total        <= r_rd + CNT_W'(!r_job.req.write_op);
            r_rsp.write_total       <= r_wr + CNT_W'(r_job.req.write_op);
            r_rsp.read_miss_total   <= r_rdm + CNT_W'(!r_job.req.write_op && !w_hit);
            r_rsp.write_miss_total  <= r_wrm + CNT_W'(r_job.req.write_op && !w_hit);
            r_rsp.dirty_evict_total <= r_dev + CNT_W'(w_ev_d);
        end
    end

    // State, sweep counter, LFSR and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_lfsr  <= LFSR_SEED;
            r_rd    <= '0;
            r_wr    <= '0;
            r_rdm   <= '0;
            r_wrm   <= '0;
            r_dev   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_wen) begin
                if (!w_hit && w_full && i_mode == MODE_RAND) r_lfsr <= w_lfsr_n;
                r_rd  <= r_rd + CNT_W'(!r_job.req.write_op);
                r_wr  <= r_wr + CNT_W'(r_job.req.write_op);
                r_rdm <= r_rdm + CNT_W'(!r_job.req.write_op && !w_hit);
                r_wrm <= r_wrm + CNT_W'(r_job.req.write_op && !w_hit);
                r_dev <= r_dev + CNT_W'(w_ev_d);
            end
        end
    end
endmodule
